>>> rtl/core/jetp_pkg.sv
// Shared types and constants for the Julia escape-time pixel unit.
`timescale 1ns / 1ps

package jetp_pkg;

  // Iteration limit and the width of the running count.
  localparam int MAX_ITER = 64;
  localparam int CNT_W    = $clog2(MAX_ITER + 1);
  localparam int ITER_W   = 7;

  // Coordinates, products and the unrounded new point.
  localparam int COORD_W = 32;
  localparam int PROD_W  = 64;
  localparam int NEXT_W  = 38;
  localparam int SPAN_W  = 24;
  localparam int PIX_W   = 16;
  localparam int CFG_W   = 32;
  localparam int COLOR_W = 24;

  // Start-point division: 32 quotient bits, one per cycle.
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // 2.0 in Q.28 and 4.0 in Q.56.
  localparam logic signed [NEXT_W-1:0] TWO_Q28     = 38'sd536870912;
  localparam logic signed [NEXT_W-1:0] NEG_TWO_Q28 = -38'sd536870912;
  localparam logic [PROD_W-1:0]        FOUR_Q56    = 64'h0400_0000_0000_0000;

  localparam logic [COLOR_W-1:0] COLOR_LIMIT = 24'h000000;
  localparam logic [COLOR_W-1:0] COLOR_EVEN  = 24'h8B1A1A;
  localparam logic [COLOR_W-1:0] COLOR_ODD   = 24'hFF0000;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_C_REAL = 2'd0,
    CFG_C_IMAG = 2'd1,
    CFG_X_SPAN = 2'd2,
    CFG_Y_SPAN = 2'd3
  } cfg_idx_t;

  localparam logic [SPAN_W-1:0] SPAN_RESET = 24'd204800;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic div_load;
    logic div_step;
    logic xy_load;
    logic mul_en;
    logic add_en;
    logic cnt_inc;
    logic upd_en;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic escaped;
    logic at_limit;
    logic stalled;
    logic out_range;
  } status_t;

endpackage

>>> rtl/core/jetp_div.sv
// Bit-serial divider that maps one pixel coordinate to its saturated Q.28 start value.
`timescale 1ns / 1ps

module jetp_div (
  input  logic                                 clk,
  input  logic                                 load,
  input  logic                                 step,
  input  logic signed [jetp_pkg::PIX_W-1:0]    pixel,
  input  logic        [jetp_pkg::SPAN_W-1:0]   span,
  output logic signed [jetp_pkg::COORD_W-1:0]  coord
);
  import jetp_pkg::*;

  logic                 neg_r;
  logic                 sat_r;
  logic [SPAN_W-1:0]    rem_r;
  logic [COORD_W-1:0]   quo_r;

  logic [SPAN_W-1:0]    span_eff;
  logic [PIX_W-1:0]     mag;
  logic [SPAN_W-1:0]    mag_sh;
  logic [SPAN_W:0]      rem_dbl;
  logic                 take;

  // A span of zero behaves as a span of one.
  assign span_eff = (span == '0) ? SPAN_W'(1) : span;
  assign mag      = pixel[PIX_W-1] ? PIX_W'(-pixel) : PIX_W'(pixel);
  assign mag_sh   = SPAN_W'({mag, 6'b0});
  assign rem_dbl  = {rem_r, 1'b0};
  assign take     = rem_dbl >= {1'b0, span_eff};

  // The numerator is mag * 2^38; a quotient of 2^32 or more is known from
  // mag * 2^6 >= span, so only the low 32 quotient bits are developed.
  always_ff @(posedge clk) begin
    if (load) begin
      neg_r <= pixel[PIX_W-1];
      sat_r <= mag_sh >= span_eff;
      rem_r <= mag_sh;
      quo_r <= '0;
    end else if (step) begin
      rem_r <= take ? SPAN_W'(rem_dbl - {1'b0, span_eff}) : rem_dbl[SPAN_W-1:0];
      quo_r <= {quo_r[COORD_W-2:0], take};
    end
  end

  always_comb begin
    if (neg_r) begin
      if (sat_r || (quo_r > 32'h8000_0000)) begin
        coord = 32'sh8000_0000;
      end else begin
        coord = $signed(-quo_r);
      end
    end else begin
      if (sat_r || quo_r[COORD_W-1]) begin
        coord = 32'sh7FFF_FFFF;
      end else begin
        coord = $signed(quo_r);
      end
    end
  end

endmodule

>>> rtl/core/jetp_dp.sv
// Datapath: start-point dividers, iteration multipliers, escape tests, count and result.
`timescale 1ns / 1ps

module jetp_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  jetp_pkg::cmd_t                       cmd,
  input  logic signed [jetp_pkg::PIX_W-1:0]    pixel_x,
  input  logic signed [jetp_pkg::PIX_W-1:0]    pixel_y,
  input  logic signed [jetp_pkg::CFG_W-1:0]    c_real,
  input  logic signed [jetp_pkg::CFG_W-1:0]    c_imag,
  input  logic        [jetp_pkg::SPAN_W-1:0]   x_span,
  input  logic        [jetp_pkg::SPAN_W-1:0]   y_span,
  output jetp_pkg::status_t                    status,
  output logic                                 out_valid,
  output logic        [jetp_pkg::ITER_W-1:0]   out_iter_count,
  output logic        [jetp_pkg::COLOR_W-1:0]  out_pixel_color
);
  import jetp_pkg::*;

  logic signed [COORD_W-1:0] x0, y0;
  logic signed [COORD_W-1:0] x_r, y_r;
  logic signed [PROD_W-1:0]  pxx_r, pyy_r, pxy_r;
  logic signed [NEXT_W-1:0]  nx_r, ny_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      out_valid_r;
  logic [ITER_W-1:0]         out_iter_r;
  logic [COLOR_W-1:0]        out_color_r;

  logic signed [PROD_W-1:0]  diff;
  logic signed [PROD_W-1:0]  diff_sh, xy_sh;
  logic signed [NEXT_W-1:0]  nx_nxt, ny_nxt;
  logic signed [NEXT_W-1:0]  x_ext;
  logic [PROD_W-1:0]         mag_sum;
  logic [COLOR_W-1:0]        color_nxt;

  jetp_div u_div_x (
    .clk   (clk),
    .load  (cmd.div_load),
    .step  (cmd.div_step),
    .pixel (pixel_x),
    .span  (x_span),
    .coord (x0)
  );

  jetp_div u_div_y (
    .clk   (clk),
    .load  (cmd.div_load),
    .step  (cmd.div_step),
    .pixel (pixel_y),
    .span  (y_span),
    .coord (y0)
  );

  // Floor shifts of the exact products, then the constant is added.
  assign diff    = pxx_r - pyy_r;
  assign diff_sh = diff >>> 28;
  assign xy_sh   = pxy_r >>> 27;
  assign nx_nxt  = $signed(diff_sh[NEXT_W-1:0]) + $signed({{6{c_real[CFG_W-1]}}, c_real});
  assign ny_nxt  = $signed(xy_sh[NEXT_W-1:0]) + $signed({{6{c_imag[CFG_W-1]}}, c_imag});

  assign x_ext   = $signed({{6{x_r[COORD_W-1]}}, x_r});
  assign mag_sum = $unsigned(pxx_r) + $unsigned(pyy_r);

  assign status.escaped   = mag_sum > FOUR_Q56;
  assign status.at_limit  = cnt_r == CNT_W'(MAX_ITER);
  assign status.stalled   = nx_r == x_ext;
  assign status.out_range = (nx_r > TWO_Q28) || (nx_r < NEG_TWO_Q28) ||
                            (ny_r > TWO_Q28) || (ny_r < NEG_TWO_Q28);

  always_comb begin
    if (cnt_r == CNT_W'(MAX_ITER)) begin
      color_nxt = COLOR_LIMIT;
    end else if (!cnt_r[0]) begin
      color_nxt = COLOR_EVEN;
    end else begin
      color_nxt = COLOR_ODD;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.xy_load) begin
      x_r <= x0;
      y_r <= y0;
    end else if (cmd.upd_en) begin
      x_r <= nx_r[COORD_W-1:0];
      y_r <= ny_r[COORD_W-1:0];
    end
    if (cmd.mul_en) begin
      pxx_r <= PROD_W'(x_r) * PROD_W'(x_r);
      pyy_r <= PROD_W'(y_r) * PROD_W'(y_r);
      pxy_r <= PROD_W'(x_r) * PROD_W'(y_r);
    end
    if (cmd.add_en) begin
      nx_r <= nx_nxt;
      ny_r <= ny_nxt;
    end
    if (cmd.finish) begin
      out_iter_r  <= ITER_W'(cnt_r);
      out_color_r <= color_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (cmd.div_load) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_iter_count  = out_iter_r;
  assign out_pixel_color = out_color_r;

endmodule

>>> rtl/core/jetp_ctrl.sv
// Controller state machine that sequences division and the escape-time iterations.
`timescale 1ns / 1ps

module jetp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  jetp_pkg::status_t   status,
  output jetp_pkg::cmd_t      cmd,
  output logic                busy
);
  import jetp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_LOAD,
    S_MUL,
    S_ADD,
    S_UPD,
    S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                 chk_r, chk_nxt;

  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    chk_nxt     = chk_r;
    cmd         = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.div_load = 1'b1;
          div_cnt_nxt  = '0;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + DIV_CNT_W'(1);
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.xy_load = 1'b1;
        chk_nxt     = 1'b0;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_ADD;
      end
      S_ADD: begin
        // The products also hold the squared magnitude of the point that
        // the last update produced; it is only tested after an update.
        cmd.add_en = 1'b1;
        state_nxt  = S_UPD;
        if (chk_r) begin
          if (status.escaped) begin
            state_nxt = S_DONE;
          end else begin
            cmd.cnt_inc = 1'b1;
          end
        end else if (status.at_limit) begin
          state_nxt = S_DONE;
        end
      end
      S_UPD: begin
        if (status.at_limit || status.stalled || status.out_range) begin
          state_nxt = S_DONE;
        end else begin
          cmd.upd_en = 1'b1;
          chk_nxt    = 1'b1;
          state_nxt  = S_MUL;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The limit check in the update state sees the count after the increment
  // made in the add state, so a loop that reaches the limit stops there.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      div_cnt_r <= '0;
      chk_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
      chk_r     <= chk_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

endmodule

>>> rtl/core/julia_escape_time_pixel_unit.sv
// Top level of the Julia escape-time pixel unit: configuration registers and core.
`timescale 1ns / 1ps

// Channel   Ports                                    Handshake
// input     in_pixel_x, in_pixel_y                   taken when start is high and busy is low
// result    out_iter_count, out_pixel_color          shown for one cycle with out_valid high
// config    cfg_we, cfg_index, cfg_wdata             written when cfg_we is high
//
// An item runs through the start-point dividers, which develop 32 quotient bits at one bit
// per cycle, then a load step and the multiply, add and update loop, which updates the
// point at most MAX_ITER times. A point that escapes on the magnitude test ends its last
// pass in the add step. Reset is synchronous and active low; it returns the controller to
// idle and the configuration registers, the iteration count and out_valid to their reset
// values. The receiver cannot stall: each result stands for exactly one cycle, and busy
// is already low in that cycle.

module julia_escape_time_pixel_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [jetp_pkg::PIX_W-1:0]    in_pixel_x,
  input  logic signed [jetp_pkg::PIX_W-1:0]    in_pixel_y,
  output logic                                 out_valid,
  output logic        [jetp_pkg::ITER_W-1:0]   out_iter_count,
  output logic        [jetp_pkg::COLOR_W-1:0]  out_pixel_color,
  input  logic                                 cfg_we,
  input  logic        [1:0]                    cfg_index,
  input  logic        [jetp_pkg::CFG_W-1:0]    cfg_wdata
);
  import jetp_pkg::*;

  // Configuration registers. The user must change them only while the unit is idle (the block
  // does not enforce this), as the datapath reads them directly throughout an item.
  logic signed [CFG_W-1:0]  c_real_r;
  logic signed [CFG_W-1:0]  c_imag_r;
  logic        [SPAN_W-1:0] x_span_r;
  logic        [SPAN_W-1:0] y_span_r;

  cmd_t    cmd;
  status_t status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_real_r <= '0;
      c_imag_r <= '0;
      x_span_r <= SPAN_RESET;
      y_span_r <= SPAN_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_C_REAL: c_real_r <= $signed(cfg_wdata);
        CFG_C_IMAG: c_imag_r <= $signed(cfg_wdata);
        CFG_X_SPAN: x_span_r <= cfg_wdata[SPAN_W-1:0];
        CFG_Y_SPAN: y_span_r <= cfg_wdata[SPAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The controller walks the division, then loops over multiply, add and
  // update; the datapath reports escape, stall, range and limit back to it.
  jetp_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  jetp_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .pixel_x         (in_pixel_x),
    .pixel_y         (in_pixel_y),
    .c_real          (c_real_r),
    .c_imag          (c_imag_r),
    .x_span          (x_span_r),
    .y_span          (y_span_r),
    .status          (status),
    .out_valid       (out_valid),
    .out_iter_count  (out_iter_count),
    .out_pixel_color (out_pixel_color)
  );

endmodule
